>>> rtl/clr_pkg.sv
// Shared types, widths and helpers for the clipped line rasteriser.
// No dependencies; used by every module of the block.
`default_nettype none

package clr_pkg;

   localparam int COORD_W          = 6;
   localparam int SIDE_W           = 7;
   localparam int ADDR_W           = 14;
   localparam int LEVEL_W          = 16;
   localparam int BYTE_W           = 8;
   localparam int ERR_W            = 10;
   localparam int LIN_W            = 13;
   localparam int CSR_INDEX_W      = 1;
   localparam int QUEUE_DEPTH      = 2;
   localparam int MAX_SIDE_DEFAULT = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_HEIGHT = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0]        start_x;
      logic [COORD_W-1:0]        start_y;
      logic [COORD_W-1:0]        end_x;
      logic [COORD_W-1:0]        end_y;
      logic signed [LEVEL_W-1:0] red_level;
      logic signed [LEVEL_W-1:0] green_level;
      logic signed [LEVEL_W-1:0] blue_level;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [ADDR_W-1:0]  byte_address;
      logic [BYTE_W-1:0]  red_byte;
      logic [BYTE_W-1:0]  green_byte;
      logic [BYTE_W-1:0]  blue_byte;
      logic               last_pixel;
   } rsp_type;

   // Classified line command as held in the queue.
   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic               sx_neg;
      logic               sy_neg;
      logic [BYTE_W-1:0]  red_byte;
      logic [BYTE_W-1:0]  green_byte;
      logic [BYTE_W-1:0]  blue_byte;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Level times 255/256, truncated, clamped to 0..255.
   function automatic logic [BYTE_W-1:0] color_byte(input logic [LEVEL_W-1:0] level);
      logic [LEVEL_W+BYTE_W-1:0] prod;
      logic [LEVEL_W-1:0]        scaled;
      logic [BYTE_W-1:0]         result;
      prod   = {level, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, level};
      scaled = prod[LEVEL_W+BYTE_W-1:BYTE_W];
      if (level[LEVEL_W-1]) begin
         result = '0;
      end else if (scaled[LEVEL_W-1:BYTE_W] != '0) begin
         result = '1;
      end else begin
         result = scaled[BYTE_W-1:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> rtl/clr_front.sv
// Front end: accepts line commands and classifies them (deltas, directions, colour bytes).
// Depends on clr_pkg.
`default_nettype none

module clr_front (
   input  wire                          start,
   input  wire clr_pkg::req_type        req_data,
   input  wire clr_pkg::queue_status_type q_status,
   output logic                         busy,
   output clr_pkg::push_type            push
);

   logic accept;

   assign busy   = q_status.full;
   assign accept = start && !busy;

   always_comb begin
      push.push            = accept;
      push.cmd.x0          = req_data.start_x;
      push.cmd.y0          = req_data.start_y;
      push.cmd.x1          = req_data.end_x;
      push.cmd.y1          = req_data.end_y;
      push.cmd.sx_neg      = !(req_data.start_x < req_data.end_x);
      push.cmd.sy_neg      = !(req_data.start_y < req_data.end_y);
      push.cmd.dx          = (req_data.end_x > req_data.start_x) ?
                             req_data.end_x - req_data.start_x :
                             req_data.start_x - req_data.end_x;
      push.cmd.dy          = (req_data.end_y > req_data.start_y) ?
                             req_data.end_y - req_data.start_y :
                             req_data.start_y - req_data.end_y;
      push.cmd.red_byte    = clr_pkg::color_byte(req_data.red_level);
      push.cmd.green_byte  = clr_pkg::color_byte(req_data.green_level);
      push.cmd.blue_byte   = clr_pkg::color_byte(req_data.blue_level);
   end

endmodule

`default_nettype wire

>>> rtl/clr_queue.sv
// Short command queue between the front end and the line walker.
// Depends on clr_pkg.
`default_nettype none

module clr_queue (
   input  wire                             clock,
   input  wire                             reset,
   input  wire clr_pkg::push_type          push,
   input  wire                             pop,
   output clr_pkg::cmd_type                head,
   output clr_pkg::queue_status_type       q_status
);

   localparam int DEPTH = clr_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   clr_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push.push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/clr_back.sv
// Back end: walks the error-term line one pixel a cycle, clips and emits pixels.
// Depends on clr_pkg. Holds one visible pixel back so the final one can be flagged.
`default_nettype none

module clr_back (
   input  wire                             clock,
   input  wire                             reset,
   input  wire clr_pkg::cmd_type           head,
   input  wire clr_pkg::queue_status_type  q_status,
   input  wire [clr_pkg::SIDE_W-1:0]       canvas_width,
   input  wire [clr_pkg::SIDE_W-1:0]       canvas_height,
   output logic                            pop,
   output logic                            rsp_valid,
   output clr_pkg::rsp_type                rsp_data
);

   localparam int COORD_W = clr_pkg::COORD_W;
   localparam int ERR_W   = clr_pkg::ERR_W;
   localparam int LIN_W   = clr_pkg::LIN_W;
   localparam int ADDR_W  = clr_pkg::ADDR_W;
   localparam int SIDE_W  = clr_pkg::SIDE_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   clr_pkg::cmd_type        cmd_ff, cmd_in;
   logic [COORD_W-1:0]      x_ff, x_in, y_ff, y_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [COORD_W-1:0]      pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic [ADDR_W-1:0]       pend_addr_ff, pend_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   clr_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                    visible, at_end, step_x, step_y;
   logic signed [ERR_W-1:0] e2, dx_s, neg_dy_s;
   logic [LIN_W-1:0]        row_base, lin_index;
   logic [ADDR_W-1:0]       addr;

   assign dx_s     = $signed({{(ERR_W-COORD_W){1'b0}}, cmd_ff.dx});
   assign neg_dy_s = -$signed({{(ERR_W-COORD_W){1'b0}}, cmd_ff.dy});
   assign e2       = err_ff <<< 1;
   assign step_x   = (e2 >= neg_dy_s);
   assign step_y   = (e2 <= dx_s);
   assign visible  = ({{(SIDE_W-COORD_W){1'b0}}, x_ff} < canvas_width) &&
                     ({{(SIDE_W-COORD_W){1'b0}}, y_ff} < canvas_height);
   assign at_end   = (x_ff == cmd_ff.x1) && (y_ff == cmd_ff.y1);

   // (x + y * width) * 3
   assign row_base  = LIN_W'({{(LIN_W-COORD_W){1'b0}}, y_ff} *
                             {{(LIN_W-SIDE_W){1'b0}}, canvas_width});
   assign lin_index = row_base + {{(LIN_W-COORD_W){1'b0}}, x_ff};
   assign addr      = ADDR_W'({lin_index, 1'b0}) + ADDR_W'(lin_index);

   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      err_in        = err_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in.pixel_x      = pend_x_ff;
      rsp_data_in.pixel_y      = pend_y_ff;
      rsp_data_in.byte_address = pend_addr_ff;
      rsp_data_in.red_byte     = cmd_ff.red_byte;
      rsp_data_in.green_byte   = cmd_ff.green_byte;
      rsp_data_in.blue_byte    = cmd_ff.blue_byte;
      rsp_data_in.last_pixel   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               cmd_in   = head;
               x_in     = head.x0;
               y_in     = head.y0;
               err_in   = $signed({{(ERR_W-COORD_W){1'b0}}, head.dx}) -
                          $signed({{(ERR_W-COORD_W){1'b0}}, head.dy});
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (visible) begin
               // release the held pixel; a later visible one exists
               rsp_valid_in  = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_x_in     = x_ff;
               pend_y_in     = y_ff;
               pend_addr_in  = addr;
            end
            if (at_end) begin
               state_in = ST_FLUSH;
            end else begin
               err_in = err_ff + (step_x ? neg_dy_s : '0) + (step_y ? dx_s : '0);
               if (step_x) begin
                  x_in = cmd_ff.sx_neg ? x_ff - 1'b1 : x_ff + 1'b1;
               end
               if (step_y) begin
                  y_in = cmd_ff.sy_neg ? y_ff - 1'b1 : y_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            rsp_valid_in           = pend_valid_ff;
            rsp_data_in.last_pixel = 1'b1;
            pend_valid_in          = 1'b0;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in      = ST_IDLE;
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      err_ff       <= err_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> rtl/clipped_line_rasterizer_unit.sv
// Clipped line rasteriser: a line of n = max(|dx|,|dy|)+1 pixels is walked by the
// one-pixel-a-cycle error-term loop. Two queued commands let start be taken while the
// walker is busy. Pixels leave on a one-cycle strobe; the receiver cannot stall.
// Synchronous reset empties the queue, idles the walker and sets both canvas sides to MAX_SIDE.
`default_nettype none

module clipped_line_rasterizer_unit #(
   parameter int MAX_SIDE = clr_pkg::MAX_SIDE_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire clr_pkg::req_type               req_data,
   output logic                                rsp_valid,
   output clr_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_write_enable,
   input  wire [clr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire [clr_pkg::SIDE_W-1:0]           csr_write_data
);

   localparam int SIDE_W = clr_pkg::SIDE_W;
   localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);

   logic [SIDE_W-1:0]          canvas_width_ff, canvas_width_in;
   logic [SIDE_W-1:0]          canvas_height_ff, canvas_height_in;
   logic [SIDE_W-1:0]          side_sat;
   clr_pkg::push_type          push;
   clr_pkg::cmd_type           head;
   clr_pkg::queue_status_type  q_status;
   logic                       pop;

   // saturate writes to the largest supported side
   assign side_sat = (csr_write_data > SIDE_LIMIT) ? SIDE_LIMIT : csr_write_data;

   always_comb begin
      canvas_width_in  = canvas_width_ff;
      canvas_height_in = canvas_height_ff;
      if (csr_write_enable) begin
         if (csr_index == clr_pkg::CSR_CANVAS_WIDTH) begin
            canvas_width_in = side_sat;
         end else if (csr_index == clr_pkg::CSR_CANVAS_HEIGHT) begin
            canvas_height_in = side_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= SIDE_LIMIT;
         canvas_height_ff <= SIDE_LIMIT;
      end else begin
         canvas_width_ff  <= canvas_width_in;
         canvas_height_ff <= canvas_height_in;
      end
   end

   clr_front u_front (
      .start    (start),
      .req_data (req_data),
      .q_status (q_status),
      .busy     (busy),
      .push     (push)
   );

   clr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   clr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .canvas_width  (canvas_width_ff),
      .canvas_height (canvas_height_ff),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

endmodule

`default_nettype wire

>>> bench/tb_clipped_line_rasterizer_unit.sv
// Self-checking bench for the clipped line rasteriser: a pixel scoreboard with its own
// line walker, plus tasks that drive line requests and canvas register writes.
// Depends on rtl/clr_pkg.sv and rtl/clipped_line_rasterizer_unit.sv.
`timescale 1ns / 1ps

class pixel_scoreboard;
   int unsigned canvas_w;
   int unsigned canvas_h;
   clr_pkg::rsp_type expected_pixels[$];
   int mismatches;
   int lines_drawn;
   int pixels_seen;

   function new();
      canvas_w    = 64;
      canvas_h    = 64;
      mismatches  = 0;
      lines_drawn = 0;
      pixels_seen = 0;
   endfunction

   // Registers saturate at the largest side.
   function void set_side(logic [clr_pkg::CSR_INDEX_W-1:0] index,
                          logic [clr_pkg::SIDE_W-1:0] value);
      int unsigned side;
      side = (value > 64) ? 64 : value;
      if (index == clr_pkg::CSR_CANVAS_WIDTH) canvas_w = side;
      else if (index == clr_pkg::CSR_CANVAS_HEIGHT) canvas_h = side;
   endfunction

   function logic [7:0] level_to_byte(logic [15:0] level);
      int unsigned scaled;
      if (level == 16'h0000 || level[15]) return 8'd0;
      scaled = (int'(level) * 255) >> 8;
      return (scaled > 255) ? 8'd255 : scaled[7:0];
   endfunction

   // Walk the error-term line and queue every pixel that lands on the canvas.
   function void rasterise_line(clr_pkg::req_type line);
      int x0, y0, x1, y1, dx, dy, sx, sy, err, e2, x, y, steps;
      logic [7:0] rb, gb, bb;
      clr_pkg::rsp_type px;
      clr_pkg::rsp_type line_pixels[$];
      x0 = line.start_x;
      y0 = line.start_y;
      x1 = line.end_x;
      y1 = line.end_y;
      rb = level_to_byte(line.red_level);
      gb = level_to_byte(line.green_level);
      bb = level_to_byte(line.blue_level);
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx + dy;
      x = x0;
      y = y0;
      for (steps = 0; steps < 64; steps++) begin
         if (x < int'(canvas_w) && y < int'(canvas_h)) begin
            px.pixel_x      = x[5:0];
            px.pixel_y      = y[5:0];
            px.byte_address = 14'((x + y * int'(canvas_w)) * 3);
            px.red_byte     = rb;
            px.green_byte   = gb;
            px.blue_byte    = bb;
            px.last_pixel   = 1'b0;
            line_pixels.push_back(px);
         end
         if (x == x1 && y == y1) break;
         e2 = 2 * err;
         if (e2 >= dy) begin
            err += dy;
            x += sx;
         end
         if (e2 <= dx) begin
            err += dx;
            y += sy;
         end
      end
      if (line_pixels.size() > 0) line_pixels[line_pixels.size()-1].last_pixel = 1'b1;
      foreach (line_pixels[i]) expected_pixels.push_back(line_pixels[i]);
   endfunction

   function void note_line(clr_pkg::req_type line);
      lines_drawn++;
      rasterise_line(line);
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task check_pixel(clr_pkg::rsp_type got);
      clr_pkg::rsp_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y));
         return;
      end
      want = expected_pixels.pop_front();
      pixels_seen++;
      if (got.pixel_x !== want.pixel_x)
         report_mismatch($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
         report_mismatch($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
      if (got.byte_address !== want.byte_address)
         report_mismatch($sformatf("byte_address %0d, want %0d (x=%0d y=%0d)",
                                   got.byte_address, want.byte_address,
                                   want.pixel_x, want.pixel_y));
      if (got.red_byte !== want.red_byte)
         report_mismatch($sformatf("red_byte %0d, want %0d", got.red_byte, want.red_byte));
      if (got.green_byte !== want.green_byte)
         report_mismatch($sformatf("green_byte %0d, want %0d", got.green_byte, want.green_byte));
      if (got.blue_byte !== want.blue_byte)
         report_mismatch($sformatf("blue_byte %0d, want %0d", got.blue_byte, want.blue_byte));
      if (got.last_pixel !== want.last_pixel)
         report_mismatch($sformatf("last_pixel %0b, want %0b (x=%0d y=%0d)",
                                   got.last_pixel, want.last_pixel,
                                   want.pixel_x, want.pixel_y));
   endtask
endclass

module tb_clipped_line_rasterizer_unit;

   localparam int DRAIN_CYCLES = 230;
   localparam int SEGMENTS     = 6;
   localparam int SEG_LINES    = 50;
   localparam longint TIMEOUT_NS = 2_000_000;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   clr_pkg::req_type                req_data;
   logic                            rsp_valid;
   clr_pkg::rsp_type                rsp_data;
   logic                            csr_write_enable;
   logic [clr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [clr_pkg::SIDE_W-1:0]      csr_write_data;

   pixel_scoreboard sb;
   int settings_used;

   clipped_line_rasterizer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (rsp_valid === 1'b1) sb.check_pixel(rsp_data);
   end

   function automatic clr_pkg::req_type mk_line(int x0, int y0, int x1, int y1,
                                                logic [15:0] r, logic [15:0] g,
                                                logic [15:0] b);
      clr_pkg::req_type line;
      line.start_x     = x0[5:0];
      line.start_y     = y0[5:0];
      line.end_x       = x1[5:0];
      line.end_y       = y1[5:0];
      line.red_level   = r;
      line.green_level = g;
      line.blue_level  = b;
      return line;
   endfunction

   function automatic logic [15:0] random_level();
      logic [15:0] corner[6];
      corner = '{16'h0000, 16'h0100, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0101};
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(16'h01FF));
         2: return corner[$urandom_range(5)];
         default: return 16'h8000 | 16'($urandom);
      endcase
   endfunction

   // Mostly lines between two random points, some short ones near a random point.
   function automatic clr_pkg::req_type random_line();
      int x0, y0, x1, y1;
      x0 = $urandom_range(63);
      y0 = $urandom_range(63);
      if ($urandom_range(3) == 0) begin
         x1 = x0 + $urandom_range(8) - 4;
         y1 = y0 + $urandom_range(8) - 4;
         x1 = (x1 < 0) ? 0 : (x1 > 63) ? 63 : x1;
         y1 = (y1 < 0) ? 0 : (y1 > 63) ? 63 : y1;
      end else begin
         x1 = $urandom_range(63);
         y1 = $urandom_range(63);
      end
      return mk_line(x0, y0, x1, y1, random_level(), random_level(), random_level());
   endfunction

   // Hold start until the request is taken, then step to the next falling edge.
   task automatic send_line(input clr_pkg::req_type line);
      start    <= 1'b1;
      req_data <= line;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_line(line);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // Drain the walker and queue before touching the canvas registers.
   task automatic set_canvas(input logic [clr_pkg::SIDE_W-1:0] w,
                             input logic [clr_pkg::SIDE_W-1:0] h);
      start <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= clr_pkg::CSR_CANVAS_WIDTH;
      csr_write_data   <= w;
      sb.set_side(clr_pkg::CSR_CANVAS_WIDTH, w);
      @(negedge clock);
      csr_index        <= clr_pkg::CSR_CANVAS_HEIGHT;
      csr_write_data   <= h;
      sb.set_side(clr_pkg::CSR_CANVAS_HEIGHT, h);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int seg_w[SEGMENTS];
      int seg_h[SEGMENTS];
      int idle_pct;
      sb = new();
      settings_used = 0;
      seg_w = '{64, 37, 1, 100, 64, 0};
      seg_h = '{64, 12, 64, 127, 1, 0};
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = clr_pkg::CSR_CANVAS_WIDTH;
      csr_write_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset canvas: single points, diagonals, straight runs and colour corners.
      send_line(mk_line( 0,  0,  0,  0, 16'h0100, 16'h0000, 16'hFFFF));
      send_line(mk_line(63, 63, 63, 63, 16'h7FFF, 16'h8000, 16'h0001));
      send_line(mk_line( 0,  0, 63, 63, 16'h00FF, 16'h0101, 16'h0080));
      send_line(mk_line(63,  0,  0, 63, 16'h0200, 16'h00FE, 16'hC000));
      send_line(mk_line( 0, 63, 63,  0, 16'h0102, 16'h0002, 16'h4000));
      send_line(mk_line(63, 63,  0,  0, 16'hFF00, 16'h0100, 16'h0100));
      send_line(mk_line( 5, 10, 60, 10, 16'h0040, 16'h00C0, 16'h0180));
      send_line(mk_line(60, 12,  3, 12, 16'h1234, 16'hABCD, 16'h00AA));
      send_line(mk_line(20,  0, 20, 63, 16'h0055, 16'h8001, 16'h7F00));
      send_line(mk_line(21, 63, 21,  0, 16'h00FF, 16'h00FF, 16'h00FF));
      // One line into each octant.
      send_line(mk_line(30, 30, 50, 40, 16'h0100, 16'h0080, 16'h0000));
      send_line(mk_line(30, 30, 40, 50, 16'h0080, 16'h0100, 16'h0000));
      send_line(mk_line(30, 30, 20, 50, 16'h0000, 16'h0100, 16'h0080));
      send_line(mk_line(30, 30, 10, 40, 16'h0000, 16'h0080, 16'h0100));
      send_line(mk_line(30, 30, 10, 20, 16'h0080, 16'h0000, 16'h0100));
      send_line(mk_line(30, 30, 20, 10, 16'h0100, 16'h0000, 16'h0080));
      send_line(mk_line(30, 30, 40, 10, 16'h0010, 16'h0020, 16'h0030));
      send_line(mk_line(30, 30, 50, 20, 16'h0030, 16'h0020, 16'h0010));
      // Partial and full clipping; the flag lands on the last visible pixel.
      set_canvas(7'd10, 7'd20);
      send_line(mk_line( 0,  0, 63, 63, 16'h0100, 16'h0100, 16'h0100));
      send_line(mk_line(40, 40, 60, 50, 16'h0100, 16'h0100, 16'h0100));
      send_line(mk_line( 5, 30,  5,  0, 16'h0100, 16'h0050, 16'h0000));
      // Zero width hides everything.
      set_canvas(7'd0, 7'd64);
      send_line(mk_line( 0,  0, 63,  0, 16'h0100, 16'h0100, 16'h0100));
      send_line(mk_line( 0,  0,  0, 63, 16'h0100, 16'h0100, 16'h0100));
      // Oversized sides saturate; bottom row reaches the top address.
      set_canvas(7'd127, 7'd65);
      send_line(mk_line( 0, 63, 63, 63, 16'h0100, 16'h0100, 16'h0100));

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == SEGMENTS - 1) begin
            seg_w[seg] = $urandom_range(1, 64);
            seg_h[seg] = $urandom_range(1, 64);
         end
         set_canvas(seg_w[seg][clr_pkg::SIDE_W-1:0], seg_h[seg][clr_pkg::SIDE_W-1:0]);
         idle_pct = (seg < 2) ? 13 : (seg < 4) ? 58 : 0;
         repeat (SEG_LINES) begin
            idle_sender(idle_pct);
            send_line(random_line());
         end
      end
      start <= 1'b0;

      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (sb.expected_pixels.size() != 0) begin
         void'(sb.expected_pixels.pop_front());
         sb.report_mismatch("expected pixel never arrived");
      end

      $display("Drew %0d lines over %0d canvas settings, %0d pixels compared.",
               sb.lines_drawn, settings_used + 1, sb.pixels_seen);
      $display("Covered all octants, clipping, zero and saturated sides, %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
